[rtl/fovc_pkg.sv]
package fovc_pkg;

  localparam int IN_W         = 16;
  localparam int OUT_W        = 17;
  localparam int XW           = 33;   // cordic vector, value * 2^29 with gain headroom
  localparam int ZW           = 34;   // residual angle, 2^32 per turn
  localparam int LW           = 32;   // gain-corrected components
  localparam int RAD_W        = 62;   // radicand width, sum of squares stays below 2^61
  localparam int SQRT_STEPS   = RAD_W / 2;
  localparam int ROOT_W       = SQRT_STEPS;
  localparam int REM_W        = ROOT_W + 3;
  localparam int QW           = 30;   // normalized magnitude, at most 2^29
  localparam int DIV_STEPS    = QW;
  localparam int DR_W         = ROOT_W + 2;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam logic signed [30:0] INV_GAIN_Q30 = 31'sd652032874;
  localparam logic [63:0]        NORM_LIMIT   = 64'h0400_0000_0000_0000;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 17'sd65535;

  typedef enum logic [1:0] {
    CFG_INVERT  = 2'd0,
    CFG_LINEAR  = 2'd1,
    CFG_ANGULAR = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                    vld;
    logic                    pose;
    logic signed [OUT_W-1:0] turn;
  } side_t;

  typedef struct packed {
    side_t                side;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    side_t                side;
    logic signed [LW-1:0] lx;
    logic signed [LW-1:0] ly;
    logic                 big;
    logic [RAD_W-1:0]     rad;
    logic [REM_W-1:0]     rem;
    logic [ROOT_W-1:0]    root;
  } sqrt_t;

  typedef struct packed {
    logic                 neg;
    logic signed [LW-1:0] l;
    logic [DR_W-1:0]      r;
    logic [QW-1:0]        q;
  } lane_t;

  typedef struct packed {
    side_t             side;
    logic              big;
    logic [ROOT_W-1:0] d;
    lane_t             ax;
    lane_t             ay;
  } div_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [31:0] atan_at(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > 64'sd65535) begin
      r = OUT_MAX;
    end else if (v < -64'sd65535) begin
      r = -OUT_MAX;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/fovc_cordic_cell.sv]
module fovc_cordic_cell
  import fovc_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  cordic_t cell_i,
  output cordic_t cell_o
);

  localparam logic [ZW-1:0] ATAN = ZW'(atan_at(STEP));

  cordic_t cell_d, cell_q;
  logic signed [XW-1:0] dx, dy;

  assign dx = cell_i.y >>> STEP;
  assign dy = cell_i.x >>> STEP;

  always_comb begin
    cell_d = cell_i;
    if (!cell_i.z[ZW-1]) begin
      cell_d.x = cell_i.x - dx;
      cell_d.y = cell_i.y + dy;
      cell_d.z = cell_i.z - $signed(ATAN);
    end else begin
      cell_d.x = cell_i.x + dx;
      cell_d.y = cell_i.y - dy;
      cell_d.z = cell_i.z + $signed(ATAN);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.side.vld <= 1'b0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

[rtl/fovc_sqrt_cell.sv]
module fovc_sqrt_cell
  import fovc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  sqrt_t cell_i,
  output sqrt_t cell_o
);

  sqrt_t cell_d, cell_q;
  logic [REM_W-1:0] trial, t;

  // one root digit per cell, two radicand bits consumed
  assign trial = {cell_i.rem[REM_W-3:0], cell_i.rad[RAD_W-1 -: 2]};
  assign t     = {1'b0, cell_i.root, 2'b01};

  always_comb begin
    cell_d     = cell_i;
    cell_d.rad = {cell_i.rad[RAD_W-3:0], 2'b00};
    if (trial >= t) begin
      cell_d.rem  = trial - t;
      cell_d.root = {cell_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      cell_d.rem  = trial;
      cell_d.root = {cell_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.side.vld <= 1'b0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

[rtl/fovc_div_cell.sv]
module fovc_div_cell
  import fovc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  div_t cell_i,
  output div_t cell_o
);

  div_t cell_d, cell_q;
  logic [DR_W-1:0] dd, rx, ry;
  logic            gx, gy;

  assign dd = {2'b00, cell_i.d};
  assign gx = cell_i.ax.r >= dd;
  assign gy = cell_i.ay.r >= dd;
  assign rx = gx ? cell_i.ax.r - dd : cell_i.ax.r;
  assign ry = gy ? cell_i.ay.r - dd : cell_i.ay.r;

  // one quotient bit per lane per cell
  always_comb begin
    cell_d      = cell_i;
    cell_d.ax.r = {rx[DR_W-2:0], 1'b0};
    cell_d.ay.r = {ry[DR_W-2:0], 1'b0};
    cell_d.ax.q = {cell_i.ax.q[QW-2:0], gx};
    cell_d.ay.q = {cell_i.ay.q[QW-2:0], gy};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.side.vld <= 1'b0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

[rtl/field_oriented_velocity_command.sv]
// channel   | dir | handshake                    | payload
// ----------+-----+------------------------------+-----------------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: stick_forward, stick_side,
//           |     |                              |   stick_turn, heading; tuser: pose_valid
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: vel_x, vel_y, vel_turn
// cfg       | in  | cfg_we_i                      | cfg_idx_i, cfg_data_i
//
// one item enters per cycle while the output is not stalled; each item passes the rotation
// cells, the square root cells (one digit each) and the divider cells (one quotient bit
// each, two lanes)
// reset clears the valid bit of every stage and loads the register defaults
// the whole chain advances together whenever the output register is empty or taken,
// so a stalled output holds every stage and s_axis_tready falls
module field_oriented_velocity_command
  import fovc_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stick_forward[15:0], stick_side[31:16], stick_turn[47:32], heading[63:48]
  input  logic [63:0] s_axis_tdata,
  // pose_valid[0]
  input  logic        s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // vel_x[16:0], vel_y[33:17], vel_turn[50:34], zero fill[55:51]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  typedef struct packed {
    side_t           side;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } prod_t;

  typedef struct packed {
    side_t                side;
    logic signed [LW-1:0] a;
    logic signed [LW-1:0] b;
  } vec_t;

  typedef struct packed {
    side_t                   side;
    logic signed [OUT_W-1:0] vx;
    logic signed [OUT_W-1:0] vy;
  } out_t;

  // configuration registers
  logic        invert_q;
  logic [15:0] lin_q, ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b0;
      lin_q    <= 16'd256;
      ang_q    <= 16'd804;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INVERT:  invert_q <= cfg_data_i[0];
        CFG_LINEAR:  lin_q    <= cfg_data_i;
        CFG_ANGULAR: ang_q    <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // global advance: every stage moves when the output register frees up
  logic en;
  out_t out_q, out_d;

  assign en            = !out_q.side.vld || m_axis_tready;
  assign s_axis_tready = en;

  // input stage: sign choice, half-turn fold, turn scaling
  logic signed [IN_W-1:0] fwd, sd, trn;
  logic [15:0]            hd, h2;
  logic signed [IN_W:0]   wx, wy;
  logic signed [XW-1:0]   x0, y0;
  logic                   fold;
  logic signed [63:0]     tprod, tround;
  cordic_t                cor [CORDIC_STEPS+1];
  cordic_t                cor_d;

  assign fwd  = s_axis_tdata[15:0];
  assign sd   = s_axis_tdata[31:16];
  assign trn  = s_axis_tdata[47:32];
  assign hd   = s_axis_tdata[63:48];
  assign wx   = invert_q ? {fwd[IN_W-1], fwd} : -{fwd[IN_W-1], fwd};
  assign wy   = invert_q ? {sd[IN_W-1], sd} : -{sd[IN_W-1], sd};
  assign x0   = {{(XW-IN_W-15){wx[IN_W]}}, wx, 14'b0};
  assign y0   = {{(XW-IN_W-15){wy[IN_W]}}, wy, 14'b0};
  assign fold = (hd > 16'd16384) && (hd < 16'd49152);
  assign h2   = fold ? hd + 16'd32768 : hd;

  assign tprod  = trn * $signed({1'b0, ang_q});
  assign tround = (tprod + 64'sd16384) >>> 15;

  always_comb begin
    cor_d.side.vld  = s_axis_tvalid;
    cor_d.side.pose = s_axis_tuser;
    cor_d.side.turn = sat_out(tround);
    cor_d.x         = fold ? -x0 : x0;
    cor_d.y         = fold ? -y0 : y0;
    cor_d.z         = {{(ZW-32){h2[15]}}, h2, 16'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cor[0].side.vld <= 1'b0;
    end else if (en) begin
      cor[0] <= cor_d;
    end
  end

  // rotation cells
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    fovc_cordic_cell #(.STEP(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (cor[i]),
      .cell_o (cor[i+1])
    );
  end

  // gain correction: multiply, then round; then square both components
  prod_t g1_q, g1_d;
  vec_t  g2_q, g2_d;
  prod_t g3_q, g3_d;
  logic signed [63:0] rxg, ryg;

  always_comb begin
    g1_d.side = cor[CORDIC_STEPS].side;
    g1_d.a    = cor[CORDIC_STEPS].x * INV_GAIN_Q30;
    g1_d.b    = cor[CORDIC_STEPS].y * INV_GAIN_Q30;
  end

  assign rxg = (g1_q.a + 64'sd536870912) >>> 30;
  assign ryg = (g1_q.b + 64'sd536870912) >>> 30;

  always_comb begin
    g2_d.side = g1_q.side;
    g2_d.a    = rxg[LW-1:0];
    g2_d.b    = ryg[LW-1:0];
    g3_d.side = g2_q.side;
    g3_d.a    = g2_q.a * g2_q.a;
    g3_d.b    = g2_q.b * g2_q.b;
  end

  // carry the components beside the squares
  vec_t g3v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_q.side.vld <= 1'b0;
      g2_q.side.vld <= 1'b0;
      g3_q.side.vld <= 1'b0;
    end else if (en) begin
      g1_q  <= g1_d;
      g2_q  <= g2_d;
      g3_q  <= g3_d;
      g3v_q <= g2_q;
    end
  end

  // sum of squares feeds the root cells
  logic [63:0] ssum;
  sqrt_t       sq [SQRT_STEPS+1];
  sqrt_t       sq_d;

  assign ssum = g3_q.a + g3_q.b;

  always_comb begin
    sq_d.side = g3_q.side;
    sq_d.lx   = g3v_q.a;
    sq_d.ly   = g3v_q.b;
    sq_d.big  = ssum > NORM_LIMIT;
    sq_d.rad  = ssum[RAD_W-1:0];
    sq_d.rem  = '0;
    sq_d.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq[0].side.vld <= 1'b0;
    end else if (en) begin
      sq[0] <= sq_d;
    end
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    fovc_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (sq[i]),
      .cell_o (sq[i+1])
    );
  end

  // divider load: magnitudes over the root
  div_t        dv [DIV_STEPS+1];
  div_t        dv_d;
  logic [LW-1:0] magx, magy;
  sqrt_t       sqt;

  assign sqt  = sq[SQRT_STEPS];
  assign magx = sqt.lx[LW-1] ? -sqt.lx : sqt.lx;
  assign magy = sqt.ly[LW-1] ? -sqt.ly : sqt.ly;

  always_comb begin
    dv_d.side  = sqt.side;
    dv_d.big   = sqt.big;
    dv_d.d     = sqt.root;
    dv_d.ax.neg = sqt.lx[LW-1];
    dv_d.ax.l   = sqt.lx;
    dv_d.ax.r   = {1'b0, magx};
    dv_d.ax.q   = '0;
    dv_d.ay.neg = sqt.ly[LW-1];
    dv_d.ay.l   = sqt.ly;
    dv_d.ay.r   = {1'b0, magy};
    dv_d.ay.q   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv[0].side.vld <= 1'b0;
    end else if (en) begin
      dv[0] <= dv_d;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    fovc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (dv[i]),
      .cell_o (dv[i+1])
    );
  end

  // pick normalized or raw vector, scale by the linear limit
  div_t               dvt;
  logic signed [LW-1:0] qx, qy, cx, cy;
  prod_t              f1_q, f1_d;
  logic signed [63:0] rvx, rvy;

  assign dvt = dv[DIV_STEPS];
  assign qx  = dvt.ax.neg ? -$signed({{(LW-QW){1'b0}}, dvt.ax.q})
                          : $signed({{(LW-QW){1'b0}}, dvt.ax.q});
  assign qy  = dvt.ay.neg ? -$signed({{(LW-QW){1'b0}}, dvt.ay.q})
                          : $signed({{(LW-QW){1'b0}}, dvt.ay.q});
  assign cx  = dvt.big ? qx : dvt.ax.l;
  assign cy  = dvt.big ? qy : dvt.ay.l;

  always_comb begin
    f1_d.side = dvt.side;
    f1_d.a    = cx * $signed({1'b0, lin_q});
    f1_d.b    = cy * $signed({1'b0, lin_q});
  end

  assign rvx = (f1_q.a + 64'sd268435456) >>> 29;
  assign rvy = (f1_q.b + 64'sd268435456) >>> 29;

  // output register, zeros when the pose is invalid
  always_comb begin
    out_d = '0;
    out_d.side.vld  = f1_q.side.vld;
    out_d.side.pose = f1_q.side.pose;
    if (f1_q.side.pose) begin
      out_d.side.turn = f1_q.side.turn;
      out_d.vx        = sat_out(rvx);
      out_d.vy        = sat_out(rvy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_q.side.vld  <= 1'b0;
      out_q.side.vld <= 1'b0;
    end else if (en) begin
      f1_q  <= f1_d;
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_q.side.vld;
  assign m_axis_tdata  = {5'b0, out_q.side.turn, out_q.vy, out_q.vx};

  // an invalid pose leaves nothing but zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_q.side.vld && !out_q.side.pose) |-> (m_axis_tdata == 56'd0))
    else $error("invalid pose item carries nonzero velocity");

  // a long vector has a root of at least 2^29
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sqt.side.vld && sqt.big) |-> (sqt.root >= ROOT_W'(32'h2000_0000)))
    else $error("root too small for a vector beyond unit length");

  // normalized magnitudes never exceed one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dvt.side.vld && dvt.big) |->
      ((dvt.ax.q <= QW'(32'h2000_0000)) && (dvt.ay.q <= QW'(32'h2000_0000))))
    else $error("normalized component beyond unit length");

  // a stall freezes the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(sq[SQRT_STEPS].side.vld) && $stable(dv[DIV_STEPS].side.vld)))
    else $error("pipeline moved during a stall");

endmodule

[tb/tb_field_oriented_velocity_command.sv]
`timescale 1ns / 1ps

module tb_field_oriented_velocity_command;
  import fovc_pkg::*;

  localparam int STEPS      = 16;
  localparam int LATENCY    = STEPS + 31 + 30 + 7;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic [63:0] s_axis_tdata;   // stick_forward, stick_side, stick_turn, heading
  logic        s_axis_tuser;   // pose_valid
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] m_axis_tdata;   // vel_x, vel_y, vel_turn, zero fill
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  field_oriented_velocity_command #(.CORDIC_STEPS(STEPS)) u_top (.*);

  // one joystick sample
  typedef struct packed {
    logic signed [15:0] fwd;
    logic signed [15:0] side;
    logic signed [15:0] turn;
    logic [15:0]        heading;
    logic               pose;
  } stick_t;

  // one velocity command
  typedef struct packed {
    logic signed [16:0] vx;
    logic signed [16:0] vy;
    logic signed [16:0] vt;
  } vel_t;

  // directed row: sample plus an optional typed-in answer
  typedef struct packed {
    stick_t s;
    logic   known;
    vel_t   v;
  } row_t;

  // local copy of the register file
  logic        inv_q;
  logic [15:0] lin_q;
  logic [15:0] ang_q;

  vel_t vel_queue[$];
  int   errors;
  int   cycles;
  bit   stall_free;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rshift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic logic signed [16:0] clamp(longint v);
    if (v > 65535) return 17'sd65535;
    if (v < -65535) return -17'sd65535;
    return v[16:0];
  endfunction

  // atan(2^-i), 2^32 per turn
  function automatic longint arc_step(int i);
    longint t[24] = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
                      64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
                      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
    return t[i];
  endfunction

  function automatic vel_t robot_frame_vel(stick_t s);
    vel_t   r;
    longint wx, wy, x, y, z, dx, dy, lx, ly, nrm;
    longint unsigned sum;
    int     h;
    r = '0;
    if (!s.pose) return r;
    wx = s.fwd;
    wy = s.side;
    if (!inv_q) begin
      wx = -wx;
      wy = -wy;
    end
    x = wx * 16384;
    y = wy * 16384;
    h = s.heading;
    // headings in the back half turn flip the vector first
    if (h > 16384 && h < 49152) begin
      x = -x;
      y = -y;
      h = (h + 32768) & 16'hFFFF;
    end
    z = ((h >= 32768) ? h - 65536 : h) * 65536;
    for (int i = 0; i < STEPS; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arc_step(i);
      end else begin
        x += dx; y -= dy; z += arc_step(i);
      end
    end
    lx = rshift(x * 652032874, 30);
    ly = rshift(y * 652032874, 30);
    sum = longint'(lx * lx) + longint'(ly * ly);
    // clip planar magnitude to unit length
    if (sum > (64'd1 << 58)) begin
      nrm = isqrt(sum);
      lx = (lx * (longint'(1) << 29)) / nrm;
      ly = (ly * (longint'(1) << 29)) / nrm;
    end
    r.vx = clamp(rshift(lx * longint'(lin_q), 29));
    r.vy = clamp(rshift(ly * longint'(lin_q), 29));
    r.vt = clamp(rshift(longint'(s.turn) * longint'(ang_q), 15));
    return r;
  endfunction

  // output side: random stalls and checks against the oldest expectation
  always @(posedge clk_i) begin
    vel_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{vx: m_axis_tdata[16:0], vy: m_axis_tdata[33:17], vt: m_axis_tdata[50:34]};
        if (vel_queue.size() == 0) begin
          $error("unexpected item vel_x=%0d", got.vx);
          errors++;
        end else begin
          want = vel_queue.pop_front();
          if (got.vx !== want.vx) begin
            $error("vel_x expected %0d got %0d", want.vx, got.vx); errors++;
          end
          if (got.vy !== want.vy) begin
            $error("vel_y expected %0d got %0d", want.vy, got.vy); errors++;
          end
          if (got.vt !== want.vt) begin
            $error("vel_turn expected %0d got %0d", want.vt, got.vt); errors++;
          end
        end
      end
      m_axis_tready <= stall_free || ($urandom_range(99) >= 9);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_INVERT:  inv_q = val[0];
      CFG_LINEAR:  lin_q = val;
      CFG_ANGULAR: ang_q = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // send one sample; the expectation is queued at acceptance
  task automatic send(stick_t s, logic known, vel_t v);
    while (!stall_free && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {s.heading, s.turn, s.side, s.fwd};
    s_axis_tuser  <= s.pose;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (known && v !== robot_frame_vel(s)) begin
      $error("table row vel_x expected %0d got %0d", v.vx, robot_frame_vel(s).vx);
      errors++;
    end
    vel_queue.push_back(known ? v : robot_frame_vel(s));
  endtask

  task automatic drain();
    int n;
    s_axis_tvalid <= 1'b0;
    while (vel_queue.size() != 0) @(posedge clk_i);
    for (n = 0; n < LATENCY + 4; n++) @(posedge clk_i);
  endtask

  function automatic stick_t rand_stick();
    stick_t s;
    s.fwd     = 16'($urandom);
    s.side    = 16'($urandom);
    s.turn    = 16'($urandom);
    s.heading = 16'($urandom);
    s.pose    = ($urandom_range(9) != 0);
    case ($urandom_range(7))
      0: s.fwd = 16'sh8000;
      1: s.side = 16'sh7FFF;
      2: begin
        s.fwd  = 16'($urandom_range(2000) - 1000);
        s.side = 16'($urandom_range(2000) - 1000);
      end
      3: s.heading = {2'($urandom_range(3)), 14'd0};
      default: ;
    endcase
    return s;
  endfunction

  row_t dir_rows[$];

  initial begin
    stick_t s;
    vel_t   none;
    errors = 0;
    cycles = 0;
    stall_free = 1'b0;
    rst_ni = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_INVERT;
    cfg_data_i = '0;
    inv_q = 1'b0;
    lin_q = 16'd256;
    ang_q = 16'd804;
    none = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: pose invalid, zero, extremes, headings on the quadrant edges
    dir_rows = '{
      '{s: '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h1234, 1'b0}, known: 1'b1, v: '0},
      '{s: '{16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF, 1'b0}, known: 1'b1, v: '0},
      '{s: '{16'sh0000, 16'sh0000, 16'sh0000, 16'h0000, 1'b1}, known: 1'b1, v: '0},
      '{s: '{16'sh7FFF, 16'sh0000, 16'sh7FFF, 16'h0000, 1'b1}, known: 1'b0, v: '0},
      '{s: '{16'sh8000, 16'sh0000, 16'sh8000, 16'h0000, 1'b1}, known: 1'b0, v: '0},
      '{s: '{16'sh0000, 16'sh7FFF, 16'sh0000, 16'h4000, 1'b1}, known: 1'b0, v: '0},
      '{s: '{16'sh4000, 16'sh4000, 16'sh0100, 16'h4001, 1'b1}, known: 1'b0, v: '0},
      '{s: '{16'sh7FFF, 16'sh7FFF, 16'sh8001, 16'h8000, 1'b1}, known: 1'b0, v: '0},
      '{s: '{16'sh8000, 16'sh8000, 16'sh0001, 16'hBFFF, 1'b1}, known: 1'b0, v: '0},
      '{s: '{16'sh1000, 16'shF000, 16'shFFFF, 16'hC000, 1'b1}, known: 1'b0, v: '0},
      '{s: '{16'sh2000, 16'sh1000, 16'sh0000, 16'hFFFF, 1'b1}, known: 1'b0, v: '0}
    };
    foreach (dir_rows[i]) send(dir_rows[i].s, dir_rows[i].known, dir_rows[i].v);
    drain();

    // extreme limits drive saturation
    write_reg(CFG_INVERT, 16'd1);
    write_reg(CFG_LINEAR, 16'hFFFF);
    write_reg(CFG_ANGULAR, 16'hFFFF);
    foreach (dir_rows[i]) send(dir_rows[i].s, 1'b0, none);
    drain();
    write_reg(CFG_LINEAR, 16'd0);
    write_reg(CFG_ANGULAR, 16'd0);
    foreach (dir_rows[i]) send(dir_rows[i].s, 1'b0, none);
    drain();

    // random phases with random register settings, one of them never idling
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_INVERT, 16'($urandom_range(1)));
      write_reg(CFG_LINEAR, (ph == 5) ? 16'hFFFF : 16'($urandom));
      write_reg(CFG_ANGULAR, 16'($urandom));
      stall_free = (ph == 2);
      for (int k = 0; k < 120; k++) begin
        s = rand_stick();
        send(s, 1'b0, none);
      end
      drain();
    end
    stall_free = 1'b0;

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/fovc_pkg.sv
rtl/fovc_cordic_cell.sv
rtl/fovc_sqrt_cell.sv
rtl/fovc_div_cell.sv
rtl/field_oriented_velocity_command.sv
tb/tb_field_oriented_velocity_command.sv
